### design/cdtd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdtd_pkg
// Shared types and constants of the color difference threshold and dilate unit.
// ----------------------------------------------------------------------------
package cdtd_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_DIFF_THRESHOLD = 2'd2;
	localparam logic [1:0] REG_TARGET_COLOR   = 2'd3;

	localparam int unsigned CFG_DW = 12;

	localparam logic [11:0] FRAME_WIDTH_RST    = 12'd640;
	localparam logic [11:0] FRAME_HEIGHT_RST   = 12'd480;
	localparam logic [8:0]  DIFF_THRESHOLD_RST = 9'd50;
	localparam logic        TARGET_COLOR_RST   = 1'b0;

	// target color codes
	localparam logic TARGET_RED  = 1'b0;
	localparam logic TARGET_BLUE = 1'b1;

	// action codes
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	// per-cell shift control
	typedef struct packed {
		logic en;
		logic load;
	} cell_ctl_t;

	// one output pixel in flight
	typedef struct packed {
		logic [10:0] row;
		logic [10:0] col;
		logic        col_zero;
		logic        right_ok;
		logic        use_above;
		logic        below;
		logic        mid_sel;
		logic        frame_end;
	} item_t;

endpackage

### design/color_diff_threshold_dilate_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_diff_threshold_dilate_unit
// Red/blue difference threshold followed by a plus-shaped 3x3 dilation over
// a raster pixel stream, with two one-bit line stores.
// ----------------------------------------------------------------------------
//  channel  direction  tdata / tuser / tlast
//  s_*      in         tdata: blue[7:0], red[15:8]; tuser: action
//  m_*      out        tdata: mask[0], row[11:1], col[22:12], pad; tlast: frame_end
//  cfg_*    in         write enable, register index, data
//
// One transaction per clock in and out while the output is not stalled; a result
// passes through line store read, window cells and output register. A pixel input
// costs one write, and every input two reads per line store RAM, in its accept
// cycle. Reset clears counters and pipeline valids; line stores are not cleared.
// Under output stall, up to three results are held before s_tready drops.
module color_diff_threshold_dilate_unit #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // blue[7:0], red[15:8]
	input  logic        s_tuser,   // action
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // mask[0], row[11:1], col[22:12], zero pad
	output logic        m_tlast,
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int SW = (CW + 1 > 12) ? CW + 1 : 12;
	localparam int SH = (RW > 12) ? RW : 12;
	localparam int RX = (RW > 11) ? RW : 11;
	localparam int CX = (CW > 11) ? CW : 11;

	// configuration registers
	logic [11:0] frame_width_q;
	logic [11:0] frame_height_q;
	logic [8:0]  diff_threshold_q;
	logic        target_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= cdtd_pkg::FRAME_WIDTH_RST;
			frame_height_q   <= cdtd_pkg::FRAME_HEIGHT_RST;
			diff_threshold_q <= cdtd_pkg::DIFF_THRESHOLD_RST;
			target_color_q   <= cdtd_pkg::TARGET_COLOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cdtd_pkg::REG_FRAME_WIDTH:    frame_width_q    <= cfg_data;
				cdtd_pkg::REG_FRAME_HEIGHT:   frame_height_q   <= cfg_data;
				cdtd_pkg::REG_DIFF_THRESHOLD: diff_threshold_q <= cfg_data[8:0];
				cdtd_pkg::REG_TARGET_COLOR:   target_color_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective frame size
	logic [SW-1:0] w_cfg, w_eff;
	logic [SH-1:0] h_cfg, h_eff;

	always_comb begin
		w_cfg = SW'(frame_width_q);
		h_cfg = SH'(frame_height_q);
		if (frame_width_q == '0) w_eff = SW'(1);
		else if (w_cfg > SW'(MAX_WIDTH)) w_eff = SW'(MAX_WIDTH);
		else w_eff = w_cfg;
		if (frame_height_q == '0) h_eff = SH'(1);
		else if (h_cfg > SH'(MAX_HEIGHT)) h_eff = SH'(MAX_HEIGHT);
		else h_eff = h_cfg;
	end

	// position counters
	logic [CW-1:0] in_col_q;
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] flush_count_q;

	// pipeline handshake
	logic v_s1, v_s2, out_valid_q;
	logic out_free, s2_ready, s1_ready, s1_adv, accept;

	assign out_free = !out_valid_q || m_tready;
	assign s2_ready = !v_s2 || out_free;
	assign s1_ready = !v_s1 || s2_ready;
	assign s1_adv   = v_s1 && s2_ready;
	assign s_tready = s1_ready;
	assign accept   = s_tvalid && s1_ready;

	// input decode and threshold
	logic [7:0]        blue, red;
	logic              is_flush;
	logic signed [9:0] diff, thr;
	logic              mark;
	logic [CW-1:0]     c_sel;
	logic [SW-1:0]     col_next;
	logic              at_end, frame_done, pix_take, emit0;
	logic [RX-1:0]     row_m1;
	logic [CX-1:0]     col_x;
	cdtd_pkg::item_t   item0;

	assign blue     = s_tdata[7:0];
	assign red      = s_tdata[15:8];
	assign is_flush = (s_tuser == cdtd_pkg::ACT_FLUSH);

	always_comb begin
		if (target_color_q == cdtd_pkg::TARGET_BLUE) begin
			diff = $signed({2'b00, blue}) - $signed({2'b00, red});
		end else begin
			diff = $signed({2'b00, red}) - $signed({2'b00, blue});
		end
		thr  = $signed({diff_threshold_q[8], diff_threshold_q});
		mark = diff > thr;
	end

	assign c_sel      = is_flush ? flush_count_q : in_col_q;
	assign col_next   = SW'(c_sel) + SW'(1);
	assign at_end     = col_next >= w_eff;
	assign frame_done = SH'(in_row_q) >= h_eff;
	assign pix_take   = !is_flush && !frame_done;
	assign emit0      = is_flush ? frame_done : (pix_take && in_row_q != '0);
	assign row_m1     = RX'(in_row_q) - RX'(1);
	assign col_x      = CX'(c_sel);

	always_comb begin
		item0.row       = row_m1[10:0];
		item0.col       = col_x[10:0];
		item0.col_zero  = (c_sel == '0);
		item0.right_ok  = !at_end;
		item0.use_above = in_row_q >= RW'(2);
		item0.below     = !is_flush && mark;
		item0.mid_sel   = !in_row_q[0];
		item0.frame_end = is_flush && at_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q      <= '0;
			in_row_q      <= '0;
			flush_count_q <= '0;
		end else if (accept) begin
			if (pix_take) begin
				if (at_end) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + RW'(1);
				end else begin
					in_col_q <= col_next[CW-1:0];
				end
			end else if (is_flush && frame_done) begin
				if (at_end) begin
					flush_count_q <= '0;
					in_row_q      <= '0;
					in_col_q      <= '0;
				end else begin
					flush_count_q <= col_next[CW-1:0];
				end
			end
		end
	end

	// line stores: bank 0 holds even rows, bank 1 odd rows
	logic we0, we1;
	logic b0_a, b0_b, b1_a, b1_b;

	assign we0 = accept && pix_take && !in_row_q[0];
	assign we1 = accept && pix_take && in_row_q[0];

	cdtd_ram #(
		.WIDTH(1),
		.DEPTH(MAX_WIDTH)
	) u_line_current (
		.clk     (clk),
		.we      (we0),
		.waddr   (c_sel),
		.wdata   (mark),
		.re      (accept),
		.raddr_a (c_sel),
		.raddr_b (col_next[CW-1:0]),
		.rdata_a (b0_a),
		.rdata_b (b0_b)
	);

	cdtd_ram #(
		.WIDTH(1),
		.DEPTH(MAX_WIDTH)
	) u_line_above (
		.clk     (clk),
		.we      (we1),
		.waddr   (c_sel),
		.wdata   (mark),
		.re      (accept),
		.raddr_a (c_sel),
		.raddr_b (col_next[CW-1:0]),
		.rdata_a (b1_a),
		.rdata_b (b1_b)
	);

	// stage 1: store data arrives
	cdtd_pkg::item_t item_s1;
	logic            mid_c, mid_c1, above_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_ready) begin
			v_s1 <= s_tvalid && emit0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item0;
		end
	end

	assign mid_c   = item_s1.mid_sel ? b1_a : b0_a;
	assign mid_c1  = item_s1.mid_sel ? b1_b : b0_b;
	assign above_c = item_s1.mid_sel ? b0_a : b1_a;

	// stage 2: window cells, left / center / right of the middle row
	cdtd_pkg::item_t   item_s2;
	logic              above_s2;
	cdtd_pkg::cell_ctl_t ctl_left, ctl_center, ctl_right;
	logic              left_q, center_q, right_q;

	always_comb begin
		ctl_right.en   = s1_adv;
		ctl_right.load = 1'b1;
		// at column zero the window restarts, else the center takes the old right
		ctl_center.en   = s1_adv;
		ctl_center.load = item_s1.col_zero;
		ctl_left.en     = s1_adv;
		ctl_left.load   = 1'b0;
	end

	cdtd_cell u_cell_right (
		.clk       (clk),
		.ctl       (ctl_right),
		.load_bit  (mid_c1),
		.shift_bit (1'b0),
		.q         (right_q)
	);

	cdtd_cell u_cell_center (
		.clk       (clk),
		.ctl       (ctl_center),
		.load_bit  (mid_c),
		.shift_bit (right_q),
		.q         (center_q)
	);

	cdtd_cell u_cell_left (
		.clk       (clk),
		.ctl       (ctl_left),
		.load_bit  (1'b0),
		.shift_bit (center_q),
		.q         (left_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_ready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			item_s2  <= item_s1;
			above_s2 <= above_c;
		end
	end

	logic dil;

	assign dil = center_q
		| (item_s2.use_above && above_s2)
		| item_s2.below
		| (!item_s2.col_zero && left_q)
		| (item_s2.right_ok && right_q);

	// output register
	logic [23:0] out_data_q;
	logic        out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && out_free) begin
			out_data_q <= {1'b0, item_s2.col, item_s2.row, dil};
			out_last_q <= item_s2.frame_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

### design/cdtd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdtd_ram
// Generic RAM, one write port and two registered read ports (read-old on
// same-address write).
// ----------------------------------------------------------------------------
module cdtd_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a_q <= mem_q[raddr_a];
			rdata_b_q <= mem_q[raddr_b];
		end
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

### design/cdtd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdtd_cell
// One column cell of the dilation window: loads a fresh mask bit or takes
// the bit of its right-hand neighbor.
// ----------------------------------------------------------------------------
module cdtd_cell (
	input  logic                clk,
	input  cdtd_pkg::cell_ctl_t ctl,
	input  logic                load_bit,
	input  logic                shift_bit,
	output logic                q
);

	logic bit_q;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			bit_q <= ctl.load ? load_bit : shift_bit;
		end
	end

	assign q = bit_q;

endmodule
